@@ hdl/hpe_pkg.sv @@
`default_nettype none

package hpe_pkg;

    // Store geometry
    localparam int MAX_BINS    = 256;
    localparam int COUNT_WIDTH = 32;
    localparam int BIN_AW      = $clog2(MAX_BINS);
    localparam int NW          = BIN_AW + 1;

    // Configuration port
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALUE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_STEP   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RECIP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT  = 2'd3;

    // Operation codes
    localparam logic [2:0] OP_ADD     = 3'd0;
    localparam logic [2:0] OP_CUM     = 3'd1;
    localparam logic [2:0] OP_PCT     = 3'd2;
    localparam logic [2:0] OP_LARGEST = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_MUL,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_TGT_RD,
        ST_TGT_MUL,
        ST_ARM,
        ST_SCAN,
        ST_PICK,
        ST_VAL_MUL,
        ST_VAL_OUT
    } state_t;

endpackage

`default_nettype wire

@@ hdl/hpe_ram.sv @@
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read.
module hpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/histogram_percentile_engine_core.sv @@
`default_nettype none

// Channel        Signals                                   Transaction at edge
// ------------   ---------------------------------------   --------------------------
// command        start, busy, operation, sample, fraction   start && !busy
// result         done, result_value, values_added           done (one-cycle strobe)
// configuration  cfg_we, cfg_addr, cfg_data                 cfg_we
//
// Add runs multiply, bin read and write back in turn; clear and unknown codes finish from idle.
// Cumulative and largest scan the n bins in use through the RAM read port. Percentile
// steps: target read and multiply, arm, scan until the target is reached, neighbor
// pick, value multiply, value out; scan and pick are skipped when not needed.
// Reset clears the per-bin valid flags at once, so no clearing pass is needed.
// Results cannot be stalled; the strobe cycle already accepts the next command.
module histogram_percentile_engine_core
    import hpe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           operation,
    input  logic [15:0]          sample,
    input  logic [16:0]          fraction,
    output logic                 done,
    output logic [31:0]          result_value,
    output logic [31:0]          values_added,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int N_CMP_W = (NW > 9) ? NW : 9;
    localparam int TP_W    = COUNT_WIDTH + 17;
    localparam int PV_W    = BIN_AW + 32;
    localparam int SUM_W   = BIN_AW + 33;

    // Registers
    state_t                  state_reg, state_next;
    logic [2:0]              op_reg, op_next;
    logic [15:0]             sample_reg, sample_next;
    logic [16:0]             frac_reg, frac_next;
    logic [15:0]             min_value_reg;
    logic [31:0]             bin_step_reg;
    logic [31:0]             step_recip_reg;
    logic [8:0]              bin_count_reg;
    logic [31:0]             added_total_reg, added_total_next;
    logic [MAX_BINS-1:0]     valid_reg, valid_next;
    logic                    rd_vld_reg;
    logic [NW-1:0]           scan_ptr_reg, scan_ptr_next;
    logic                    pend_reg, pend_next;
    logic [BIN_AW-1:0]       pend_idx_reg, pend_idx_next;
    logic [COUNT_WIDTH-1:0]  acc_reg, acc_next;
    logic [COUNT_WIDTH-1:0]  hi_reg, hi_next;
    logic [COUNT_WIDTH-1:0]  tgt_reg, tgt_next;
    logic [BIN_AW-1:0]       idx_reg, idx_next;
    logic [47:0]             prod_add_reg, prod_add_next;
    logic [PV_W-1:0]         prod_val_reg, prod_val_next;
    logic                    done_reg, done_next;
    logic [31:0]             result_reg, result_next;
    logic [31:0]             total_out_reg, total_out_next;

    // RAM port signals
    logic                    ram_we;
    logic [BIN_AW-1:0]       ram_waddr;
    logic [COUNT_WIDTH-1:0]  ram_wdata;
    logic                    ram_re;
    logic [BIN_AW-1:0]       ram_raddr;
    logic [COUNT_WIDTH-1:0]  ram_rdata;

    // Shared combinational terms
    logic [N_CMP_W-1:0]      bc_ext;
    logic [N_CMP_W-1:0]      n_cmp;
    logic [NW-1:0]           n_use;
    logic [BIN_AW-1:0]       last_idx;
    logic [COUNT_WIDTH-1:0]  rd_data_m;
    logic                    issue_ok;
    logic                    pend_last;
    logic                    pct_hit;
    logic                    scan_end;
    logic [15:0]             diff;
    logic [31:0]             bin_raw;
    logic [TP_W-1:0]         tgt_prod;
    logic [COUNT_WIDTH-1:0]  dist_lo;
    logic [COUNT_WIDTH-1:0]  dist_hi;
    logic [SUM_W-1:0]        val_sum;
    logic [SUM_W-17:0]       val_shift;

    hpe_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (MAX_BINS)
    ) u_bins (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Bins in use: zero acts as one, clamp at store depth
    always_comb
    begin
        bc_ext = N_CMP_W'(bin_count_reg);
        if (bc_ext == '0)
        begin
            n_cmp = N_CMP_W'(1);
        end
        else if (bc_ext > N_CMP_W'(MAX_BINS))
        begin
            n_cmp = N_CMP_W'(MAX_BINS);
        end
        else
        begin
            n_cmp = bc_ext;
        end
    end

    assign n_use     = NW'(n_cmp);
    assign last_idx  = BIN_AW'(n_use - NW'(1));

    // Never-written bins read as zero
    assign rd_data_m = rd_vld_reg ? ram_rdata : '0;

    // Scan control
    assign issue_ok  = (scan_ptr_reg < n_use);
    assign pend_last = (pend_idx_reg == last_idx);
    assign pct_hit   = (rd_data_m >= tgt_reg);
    assign scan_end  = pend_reg && (pend_last || ((op_reg == OP_PCT) && pct_hit));

    // Arithmetic terms
    assign diff      = (sample_reg > min_value_reg) ? (sample_reg - min_value_reg) : 16'h0;
    assign bin_raw   = prod_add_reg[47:16];
    assign tgt_prod  = TP_W'(rd_data_m) * TP_W'(frac_reg);
    assign dist_lo   = (tgt_reg >= acc_reg) ? (tgt_reg - acc_reg) : (acc_reg - tgt_reg);
    assign dist_hi   = (tgt_reg >= hi_reg) ? (tgt_reg - hi_reg) : (hi_reg - tgt_reg);
    assign val_sum   = SUM_W'({min_value_reg, 16'h0}) + SUM_W'(prod_val_reg);
    // Bin index stays narrow enough that the value always fits 32 bits
    assign val_shift = val_sum[SUM_W-1:16];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (operation)
                        OP_ADD:     state_next = ST_ADD_MUL;
                        OP_CUM:     state_next = ST_SCAN;
                        OP_LARGEST: state_next = ST_SCAN;
                        OP_PCT:     state_next = ST_TGT_RD;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ADD_MUL: state_next = ST_ADD_RD;
            ST_ADD_RD:  state_next = ST_ADD_WR;
            ST_ADD_WR:  state_next = ST_IDLE;
            ST_TGT_RD:  state_next = ST_TGT_MUL;
            ST_TGT_MUL: state_next = ST_ARM;
            ST_ARM:
            begin
                state_next = (tgt_reg == '0) ? ST_VAL_MUL : ST_SCAN;
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    if (op_reg == OP_PCT)
                    begin
                        state_next = (pend_idx_reg == '0) ? ST_VAL_MUL : ST_PICK;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PICK:    state_next = ST_VAL_MUL;
            ST_VAL_MUL: state_next = ST_VAL_OUT;
            ST_VAL_OUT: state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        op_next          = op_reg;
        sample_next      = sample_reg;
        frac_next        = frac_reg;
        added_total_next = added_total_reg;
        valid_next       = valid_reg;
        scan_ptr_next    = scan_ptr_reg;
        pend_next        = 1'b0;
        pend_idx_next    = pend_idx_reg;
        acc_next         = acc_reg;
        hi_next          = hi_reg;
        tgt_next         = tgt_reg;
        idx_next         = idx_reg;
        prod_add_next    = prod_add_reg;
        prod_val_next    = prod_val_reg;
        done_next        = 1'b0;
        result_next      = result_reg;
        total_out_next   = total_out_reg;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = '0;
        ram_re           = 1'b0;
        ram_raddr        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next       = operation;
                    sample_next   = sample;
                    frac_next     = (fraction > 17'h10000) ? 17'h10000 : fraction;
                    scan_ptr_next = '0;
                    case (operation)
                        OP_ADD, OP_CUM, OP_PCT, OP_LARGEST:
                        begin
                        end
                        OP_CLEAR:
                        begin
                            valid_next       = '0;
                            added_total_next = '0;
                            done_next        = 1'b1;
                            result_next      = '0;
                            total_out_next   = '0;
                        end
                        default:
                        begin
                            done_next      = 1'b1;
                            result_next    = '0;
                            total_out_next = added_total_reg;
                        end
                    endcase
                end
            end

            // Bin mapping product
            ST_ADD_MUL:
            begin
                prod_add_next = 48'(diff) * 48'(step_recip_reg);
            end

            // Clamp and read the bin
            ST_ADD_RD:
            begin
                if (bin_raw >= 32'(n_use))
                begin
                    idx_next = last_idx;
                end
                else
                begin
                    idx_next = BIN_AW'(bin_raw);
                end
                ram_re    = 1'b1;
                ram_raddr = idx_next;
            end

            // Increment and write back
            ST_ADD_WR:
            begin
                ram_we              = 1'b1;
                ram_waddr           = idx_reg;
                ram_wdata           = rd_data_m + COUNT_WIDTH'(1);
                valid_next[idx_reg] = 1'b1;
                added_total_next    = added_total_reg + 32'd1;
                done_next           = 1'b1;
                result_next         = 32'(idx_reg);
                total_out_next      = added_total_reg + 32'd1;
            end

            ST_TGT_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = last_idx;
            end

            ST_TGT_MUL:
            begin
                tgt_next = COUNT_WIDTH'(tgt_prod >> 16);
            end

            ST_ARM:
            begin
                idx_next      = '0;
                scan_ptr_next = '0;
            end

            ST_SCAN:
            begin
                // Consume the bin returned from last cycle's read
                if (pend_reg)
                begin
                    case (op_reg)
                        OP_CUM:
                        begin
                            if (pend_idx_reg == '0)
                            begin
                                acc_next = rd_data_m;
                            end
                            else
                            begin
                                ram_we                   = 1'b1;
                                ram_waddr                = pend_idx_reg;
                                ram_wdata                = rd_data_m + acc_reg;
                                valid_next[pend_idx_reg] = 1'b1;
                                acc_next                 = rd_data_m + acc_reg;
                            end
                        end
                        OP_LARGEST:
                        begin
                            if ((pend_idx_reg == '0) || (rd_data_m > acc_reg))
                            begin
                                acc_next = rd_data_m;
                                idx_next = pend_idx_reg;
                            end
                        end
                        OP_PCT:
                        begin
                            if (pct_hit || pend_last)
                            begin
                                hi_next  = rd_data_m;
                                idx_next = pend_idx_reg;
                            end
                            else
                            begin
                                acc_next = rd_data_m;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end

                if (scan_end)
                begin
                    if (op_reg != OP_PCT)
                    begin
                        done_next      = 1'b1;
                        result_next    = (op_reg == OP_LARGEST) ? 32'(idx_next) : 32'h0;
                        total_out_next = added_total_reg;
                    end
                end
                else if (issue_ok)
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = scan_ptr_reg[BIN_AW-1:0];
                    scan_ptr_next = scan_ptr_reg + NW'(1);
                    pend_next     = 1'b1;
                    pend_idx_next = scan_ptr_reg[BIN_AW-1:0];
                end
            end

            // Closer of the bin that reached the target and the one before it
            ST_PICK:
            begin
                if (dist_lo < dist_hi)
                begin
                    idx_next = idx_reg - BIN_AW'(1);
                end
            end

            ST_VAL_MUL:
            begin
                prod_val_next = PV_W'(idx_reg) * PV_W'(bin_step_reg);
            end

            ST_VAL_OUT:
            begin
                done_next      = 1'b1;
                result_next    = 32'(val_shift);
                total_out_next = added_total_reg;
            end

            default:
            begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            added_total_reg <= '0;
            valid_reg       <= '0;
            pend_reg        <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            added_total_reg <= added_total_next;
            valid_reg       <= valid_next;
            pend_reg        <= pend_next;
            done_reg        <= done_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_value_reg  <= 16'd0;
            bin_step_reg   <= 32'd16777216;
            step_recip_reg <= 32'd256;
            bin_count_reg  <= 9'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_MIN_VALUE:  min_value_reg  <= cfg_data[15:0];
                CFG_BIN_STEP:   bin_step_reg   <= cfg_data[31:0];
                CFG_STEP_RECIP: step_recip_reg <= cfg_data[31:0];
                CFG_BIN_COUNT:  bin_count_reg  <= cfg_data[8:0];
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        sample_reg    <= sample_next;
        frac_reg      <= frac_next;
        scan_ptr_reg  <= scan_ptr_next;
        pend_idx_reg  <= pend_idx_next;
        acc_reg       <= acc_next;
        hi_reg        <= hi_next;
        tgt_reg       <= tgt_next;
        idx_reg       <= idx_next;
        prod_add_reg  <= prod_add_next;
        prod_val_reg  <= prod_val_next;
        result_reg    <= result_next;
        total_out_reg <= total_out_next;
        if (ram_re)
        begin
            rd_vld_reg <= valid_reg[ram_raddr];
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign result_value = result_reg;
    assign values_added = total_out_reg;

    // Checks
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    a_cmd_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted command neither started nor finished");

    a_finish_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("sequencer went idle without a result");

    a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == ST_ADD_WR) || ((state_reg == ST_SCAN) && (op_reg == OP_CUM))))
        else $error("bin store written outside add or cumulative");

    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == OP_CLEAR)) |=> ((valid_reg == '0) && (values_added == '0)))
        else $error("clear left bins or total behind");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import hpe_pkg::*;

    // Operation codes the block does not define; it must answer them with zero
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam int DRAIN_CYCLES = 300;

    // One queued request: either a command or a register write
    typedef struct packed {
        bit                   is_cfg;
        logic [2:0]           op;
        logic [15:0]          smp;
        logic [16:0]          frac;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_data;
    } hist_req_t;

    // What the block should answer for one command
    typedef struct packed {
        logic [31:0] value;
        logic [31:0] added;
    } answer_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [2:0]           operation = OP_ADD;
    logic [15:0]          sample = '0;
    logic [16:0]          fraction = '0;
    logic                 done;
    logic [31:0]          result_value;
    logic [31:0]          values_added;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = CFG_MIN_VALUE;
    logic [CFG_W-1:0]     cfg_data = '0;

    hist_req_t request_q[$];
    answer_t   predicted_answers[$];

    // Histogram state as the block should hold it
    logic [COUNT_WIDTH-1:0] bin_tally [MAX_BINS];
    logic [31:0]            sample_total;
    logic [15:0]            lo_edge;
    logic [31:0]            width_q16;
    logic [31:0]            inv_width;
    logic [8:0]             nbins_cfg;

    // Driver and bookkeeping
    logic        cmd_taken = 1'b0;
    int unsigned gap_left = 0;
    int unsigned quiet_run = 0;
    int unsigned fail_count = 0;
    int unsigned cfg_writes = 0;
    int unsigned op_seen [8];
    int unsigned queued_cmds = 0;
    int unsigned setups = 0;

    // Stimulus shaping only
    int unsigned gen_min = 0;
    int unsigned gen_bins = MAX_BINS;
    int unsigned gen_span = 65535;

    histogram_percentile_engine_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .sample       (sample),
        .fraction     (fraction),
        .done         (done),
        .result_value (result_value),
        .values_added (values_added),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] count_gap(logic [63:0] a, logic [63:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // Register write as the block should see it
    function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            CFG_MIN_VALUE:  lo_edge   = data[15:0];
            CFG_BIN_STEP:   width_q16 = data;
            CFG_STEP_RECIP: inv_width = data;
            CFG_BIN_COUNT:  nbins_cfg = data[8:0];
            default: ;
        endcase
    endfunction

    // Applies one command to the histogram state and returns its answer
    function automatic answer_t compute_answer(logic [2:0] op, logic [15:0] smp,
                                               logic [16:0] frac);
        answer_t     ans;
        int unsigned n_used;
        int unsigned scanned;
        int unsigned idx;
        int unsigned best;
        logic [63:0] bin_no;
        logic [63:0] target;
        logic [63:0] last;
        logic [63:0] val;
        logic [63:0] most;
        logic [16:0] frac_sat;
        n_used = (nbins_cfg == 0) ? 1 : (nbins_cfg > MAX_BINS) ? MAX_BINS : nbins_cfg;
        ans.value = '0;
        case (op)
            OP_ADD:
            begin
                bin_no = '0;
                if (smp > lo_edge)
                    bin_no = (64'(smp - lo_edge) * 64'(inv_width)) >> 16;
                if (bin_no >= n_used)
                    bin_no = 64'(n_used - 1);
                bin_tally[bin_no] = bin_tally[bin_no] + 1'b1;
                sample_total = sample_total + 1;
                ans.value = bin_no[31:0];
            end
            OP_CUM:
            begin
                for (int i = 1; i < n_used; i++)
                    bin_tally[i] = bin_tally[i] + bin_tally[i-1];
            end
            OP_PCT:
            begin
                frac_sat = (frac > 17'd65536) ? 17'd65536 : frac;
                target = (64'(bin_tally[n_used-1]) * 64'(frac_sat)) >> 16;
                last = '0;
                scanned = 0;
                idx = 0;
                while (scanned < n_used && last < target)
                begin
                    last = 64'(bin_tally[scanned]);
                    scanned++;
                end
                // Closer of the crossing bin and its predecessor; ties go up
                if (scanned >= 2)
                    idx = (count_gap(target, 64'(bin_tally[scanned-2]))
                           < count_gap(target, 64'(bin_tally[scanned-1])))
                          ? scanned - 2 : scanned - 1;
                val = ((64'(lo_edge) << 16) + 64'(idx) * 64'(width_q16)) >> 16;
                ans.value = (val > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : val[31:0];
            end
            OP_LARGEST:
            begin
                best = 0;
                most = 64'(bin_tally[0]);
                for (int i = 1; i < n_used; i++)
                begin
                    if (64'(bin_tally[i]) > most)
                    begin
                        most = 64'(bin_tally[i]);
                        best = i;
                    end
                end
                ans.value = best;
            end
            OP_CLEAR:
            begin
                foreach (bin_tally[i])
                    bin_tally[i] = '0;
                sample_total = '0;
            end
            default: ;
        endcase
        ans.added = sample_total;
        return ans;
    endfunction

    task automatic queue_op(logic [2:0] op, logic [15:0] smp, logic [16:0] frac);
        hist_req_t r;
        r = '0;
        r.op = op;
        r.smp = smp;
        r.frac = frac;
        request_q.push_back(r);
        queued_cmds++;
    endtask

    task automatic queue_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        hist_req_t r;
        r = '0;
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_data = data;
        request_q.push_back(r);
    endtask

    // One setup: new registers, a batch of adds, prefix sums, queries, then sometimes a clear
    task automatic queue_random_phase();
        int unsigned roll;
        int unsigned n_eff;
        int unsigned smp;
        roll = $urandom_range(0, 15);
        if (roll == 0)
            gen_bins = 0;
        else if (roll == 1)
            gen_bins = $urandom_range(MAX_BINS + 1, 511);
        else if (roll == 2)
            gen_bins = MAX_BINS;
        else if (roll == 3)
            gen_bins = $urandom_range(MAX_BINS / 2, MAX_BINS - 1);
        else
            gen_bins = $urandom_range(1, 24);
        n_eff = (gen_bins == 0) ? 1 : (gen_bins > MAX_BINS) ? MAX_BINS : gen_bins;

        if ($urandom_range(0, 3) != 0)
        begin
            gen_min = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, 2000);
            queue_cfg(CFG_MIN_VALUE, gen_min);
        end
        gen_span = (gen_min > 65535 - 64) ? 64 : $urandom_range(64, 65535 - gen_min);
        queue_cfg(CFG_BIN_COUNT, gen_bins);
        // Reciprocal mostly matched to the sample span so adds spread over the bins
        if ($urandom_range(0, 3) != 0)
            queue_cfg(CFG_STEP_RECIP, ($urandom_range(0, 7) == 0)
                      ? $urandom() : (n_eff * 65536) / gen_span + $urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0)
            queue_cfg(CFG_BIN_STEP, ($urandom_range(0, 7) == 0)
                      ? $urandom() : $urandom_range(1, 64 * 65536));
        setups++;

        repeat ($urandom_range(4, 40))
        begin
            if ($urandom_range(0, 7) == 0)
                smp = $urandom_range(0, 65535);
            else
                smp = gen_min + $urandom_range(0, gen_span);
            if (smp > 65535)
                smp = 65535;
            queue_op(OP_ADD, 16'(smp), 17'($urandom_range(0, 131071)));
            // Occasional stray command in the middle of the batch
            if ($urandom_range(0, 11) == 0)
                queue_op(3'($urandom_range(OP_ADD, OP_SPARE_HI)),
                         16'($urandom_range(0, 65535)), 17'($urandom_range(0, 131071)));
        end
        repeat ($urandom_range(0, 3))
            queue_op(OP_CUM, 16'($urandom_range(0, 65535)), 17'($urandom_range(0, 131071)));
        repeat ($urandom_range(2, 8))
        begin
            if ($urandom_range(0, 4) == 0)
                queue_op(OP_LARGEST, 16'($urandom_range(0, 65535)),
                         17'($urandom_range(0, 131071)));
            else
                queue_op(OP_PCT, 16'($urandom_range(0, 65535)),
                         17'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 131071)
                                                         : $urandom_range(0, 65536)));
        end
        if ($urandom_range(0, 2) == 0)
            queue_op(OP_CLEAR, 16'($urandom_range(0, 65535)), 17'($urandom_range(0, 131071)));
    endtask

    // Driver: presents requests at the falling edge
    always @(negedge clk)
    begin : drive_proc
        logic      launch_start;
        logic      launch_we;
        hist_req_t req;
        launch_start = start;
        launch_we = 1'b0;
        if (rst_n)
        begin
            if (start && cmd_taken)
                launch_start = 1'b0;
            if (!launch_start)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (request_q.size() > 0)
                begin
                    if (request_q[0].is_cfg)
                    begin
                        // Registers change only with the block idle and drained
                        if (predicted_answers.size() == 0 && !busy)
                        begin
                            req = request_q.pop_front();
                            launch_we = 1'b1;
                            cfg_addr <= req.reg_idx;
                            cfg_data <= req.reg_data;
                        end
                    end
                    else
                    begin
                        req = request_q.pop_front();
                        launch_start = 1'b1;
                        operation <= req.op;
                        sample <= req.smp;
                        fraction <= req.frac;
                        if (quiet_run > 0)
                        begin
                            quiet_run <= quiet_run - 1;
                            gap_left <= 0;
                        end
                        else
                        begin
                            gap_left <= $urandom_range(0, 6);
                            if ($urandom_range(0, 39) == 0)
                                quiet_run <= $urandom_range(20, 60);
                        end
                    end
                end
            end
        end
        start <= launch_start;
        cfg_we <= launch_we;
    end

    // Monitor: checks results, tracks writes and accepted commands
    always @(posedge clk)
    begin : watch_proc
        answer_t want;
        cmd_taken <= start && !busy;
        if (rst_n)
        begin
            if (done)
            begin
                if (predicted_answers.size() == 0)
                begin
                    $error("result with no command outstanding: result_value %0d, values_added %0d",
                           result_value, values_added);
                    fail_count++;
                end
                else
                begin
                    want = predicted_answers.pop_front();
                    if (result_value !== want.value)
                    begin
                        $error("result_value: expected %0d, got %0d", want.value, result_value);
                        fail_count++;
                    end
                    if (values_added !== want.added)
                    begin
                        $error("values_added: expected %0d, got %0d", want.added, values_added);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                apply_config(cfg_addr, cfg_data);
                cfg_writes++;
            end
            if (start && !busy)
            begin
                predicted_answers.push_back(compute_answer(operation, sample, fraction));
                op_seen[operation]++;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        foreach (bin_tally[i])
            bin_tally[i] = '0;
        sample_total = '0;
        lo_edge = '0;
        width_q16 = 32'd16777216;
        inv_width = 32'd256;
        nbins_cfg = 9'd256;

        // Directed: reset registers, edges of the sample range, all operations
        queue_op(OP_ADD, 16'd0, 17'd0);
        queue_op(OP_ADD, 16'hFFFF, 17'h1FFFF);
        queue_op(OP_ADD, 16'd1000, 17'd0);
        queue_op(OP_LARGEST, 16'd0, 17'd0);
        queue_op(OP_PCT, 16'd0, 17'd65536);
        queue_op(OP_PCT, 16'd0, 17'd0);
        queue_op(OP_PCT, 16'hFFFF, 17'h1FFFF);
        queue_op(OP_SPARE_LO, 16'hFFFF, 17'h1FFFF);
        queue_op(OP_SPARE_HI, 16'd0, 17'd0);
        queue_op(OP_CUM, 16'd0, 17'd0);
        queue_op(OP_PCT, 16'd0, 17'd32768);
        // Repeated prefix sums over all bins push the counters past wrap
        repeat (5)
            queue_op(OP_CUM, 16'd0, 17'd0);
        queue_op(OP_LARGEST, 16'd0, 17'd0);
        queue_op(OP_PCT, 16'd0, 17'd65536);
        queue_op(OP_CLEAR, 16'd0, 17'd0);

        // Top of the step and reciprocal registers, a high minimum value; bin count above the store size
        queue_cfg(CFG_MIN_VALUE, 32'd60000);
        queue_cfg(CFG_BIN_STEP, 32'hFFFF_FFFF);
        queue_cfg(CFG_STEP_RECIP, 32'hFFFF_FFFF);
        queue_cfg(CFG_BIN_COUNT, 32'd511);
        queue_op(OP_ADD, 16'd60001, 17'd0);
        queue_op(OP_PCT, 16'd0, 17'd65536);
        queue_op(OP_ADD, 16'd100, 17'd0);
        queue_op(OP_SPARE_HI - 3'd1, 16'd0, 17'd0);

        // Bin count zero acts as a single bin
        queue_cfg(CFG_BIN_COUNT, 32'd0);
        queue_op(OP_ADD, 16'hFFFF, 17'd0);
        queue_op(OP_PCT, 16'd0, 17'd65536);

        while (queued_cmds < 1500)
            queue_random_phase();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (request_q.size() != 0 || start || predicted_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d add, %0d cumulative, %0d percentile, %0d largest, %0d clear",
                 op_seen[OP_ADD], op_seen[OP_CUM], op_seen[OP_PCT], op_seen[OP_LARGEST],
                 op_seen[OP_CLEAR]);
        $display("and %0d undefined commands across %0d register writes in %0d random setups",
                 op_seen[OP_SPARE_LO] + op_seen[OP_SPARE_LO + 3'd1] + op_seen[OP_SPARE_HI],
                 cfg_writes, setups);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("timeout: %0d results still outstanding", predicted_answers.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/hpe_pkg.sv
hdl/hpe_ram.sv
hdl/histogram_percentile_engine_core.sv
dv/tb_top.sv
